>>> rtl/msd_pkg.sv
// Shared types, constants and codes for the microslice stream deframer.
package msd_pkg;

  localparam int unsigned WORD_BYTES   = 4;
  localparam int unsigned HEADER_BYTES = 16;

  localparam logic [15:0] SLICES_PER_BLOCK_RST = 16'd1;
  localparam logic [31:0] SAFE_WORD_RST        = 32'h708b309e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICES_PER_BLOCK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE_WORD        = 8'd1;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] write_offset;
    logic        block_done;
    logic [31:0] block_bytes;
    logic [15:0] block_slices;
    logic        seq_mismatch;
    logic [31:0] got_seq;
    logic [31:0] expected_seq;
    logic        resync_found;
    logic        size_error;
    logic [31:0] blocks_total;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic        cmd;
    logic [31:0] word;
    logic        is_safe;
    logic        size_bad;
    logic        size_hdr_only;
  } cls_item_t;

endpackage

>>> rtl/msd_front.sv
// Front end: accepts input requests and classifies each word.
module msd_front (
  input  msd_pkg::in_item_t  in_data,
  input  logic [31:0]        safe_word,
  output msd_pkg::cls_item_t cls
);

  // Precompute the compares the back end needs
  always_comb begin
    cls.cmd           = in_data.cmd;
    cls.word          = in_data.data_word;
    cls.is_safe       = (in_data.data_word == safe_word);
    cls.size_bad      = (in_data.data_word < 32'(msd_pkg::HEADER_BYTES)) ||
                        (in_data.data_word[1:0] != 2'b00);
    cls.size_hdr_only = (in_data.data_word == 32'(msd_pkg::HEADER_BYTES));
  end

endmodule

>>> rtl/msd_queue.sv
// Short FIFO between the front and back ends.
module msd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  msd_pkg::cls_item_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output msd_pkg::cls_item_t pop_data
);

  msd_pkg::cls_item_t                mem_r [msd_pkg::QUEUE_DEPTH];
  logic [msd_pkg::QPTR_W-1:0]        wptr_r, wptr_nxt;
  logic [msd_pkg::QPTR_W-1:0]        rptr_r, rptr_nxt;
  logic [msd_pkg::QCNT_W-1:0]        count_r, count_nxt;

  assign full      = (count_r == msd_pkg::QCNT_W'(msd_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rptr_r];

  // Pointer and fill count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == msd_pkg::QPTR_W'(msd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == msd_pkg::QPTR_W'(msd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/msd_back.sv
// Back end: deframing state, block accounting and the result register.
module msd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  msd_pkg::cls_item_t q_data,
  output logic               q_pop,
  input  logic [15:0]        slices_per_block,
  output logic               out_valid,
  input  logic               out_ready,
  output msd_pkg::out_item_t out_data
);

  msd_pkg::phase_t    phase_r, phase_nxt;
  logic [1:0]         hidx_r, hidx_nxt;
  logic [31:0]        slice_bytes_r, slice_bytes_nxt;
  logic [31:0]        slice_size_r, slice_size_nxt;
  logic               size_bad_r, size_bad_nxt;
  logic               size_hdr_r, size_hdr_nxt;
  logic [15:0]        slices_r, slices_nxt;
  logic [31:0]        block_bytes_r, block_bytes_nxt;
  logic [31:0]        last_seq_r, last_seq_nxt;
  logic               seq_valid_r, seq_valid_nxt;
  logic               block_open_r, block_open_nxt;
  logic [31:0]        block_count_r, block_count_nxt;
  logic [31:0]        hdr_seq_r, hdr_seq_nxt;
  logic               out_valid_r;
  msd_pkg::out_item_t out_r, out_nxt;

  logic        take;
  logic        data_take;
  logic [31:0] bbs, sbs, sbs1, seq_inc;
  logic [15:0] sib, sib1;
  logic        hdr_last, mis, close_slice, done;

  // Pull from the queue whenever the result register is free or draining
  assign take      = q_valid && (!out_valid_r || out_ready);
  assign data_take = take && !q_data.cmd;
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Shared conditions; a closed block reopens with cleared counters
  assign bbs      = block_open_r ? block_bytes_r : '0;
  assign sbs      = block_open_r ? slice_bytes_r : '0;
  assign sib      = block_open_r ? slices_r : '0;
  assign sbs1     = sbs + 32'(msd_pkg::WORD_BYTES);
  assign seq_inc  = last_seq_r + 32'd1;
  assign hdr_last = (phase_r != msd_pkg::PH_PAYLOAD) &&
                    (phase_r != msd_pkg::PH_DISCARD) && (hidx_r == 2'd3);
  assign mis      = hdr_last && seq_valid_r && (hdr_seq_r != seq_inc);
  assign close_slice =
      ((phase_r == msd_pkg::PH_PAYLOAD) && (sbs1 == slice_size_r)) ||
      ((phase_r == msd_pkg::PH_DISCARD) && q_data.is_safe) ||
      (hdr_last && !mis && !size_bad_r && size_hdr_r);
  assign sib1 = close_slice ? sib + 16'd1 : sib;
  assign done = (sib1 == slices_per_block);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      if (q_data.cmd) begin
        phase_nxt = msd_pkg::PH_HEADER;
      end else begin
        case (phase_r)
          msd_pkg::PH_PAYLOAD: begin
            phase_nxt = close_slice ? msd_pkg::PH_HEADER : msd_pkg::PH_PAYLOAD;
          end
          msd_pkg::PH_DISCARD: begin
            phase_nxt = q_data.is_safe ? msd_pkg::PH_HEADER : msd_pkg::PH_DISCARD;
          end
          default: begin
            if (!hdr_last) begin
              phase_nxt = msd_pkg::PH_HEADER;
            end else if (mis || size_bad_r) begin
              phase_nxt = msd_pkg::PH_DISCARD;
            end else if (size_hdr_r) begin
              phase_nxt = msd_pkg::PH_HEADER;
            end else begin
              phase_nxt = msd_pkg::PH_PAYLOAD;
            end
          end
        endcase
      end
    end
  end

  // Datapath and result
  always_comb begin
    hidx_nxt        = hidx_r;
    slice_bytes_nxt = slice_bytes_r;
    slice_size_nxt  = slice_size_r;
    size_bad_nxt    = size_bad_r;
    size_hdr_nxt    = size_hdr_r;
    slices_nxt      = slices_r;
    block_bytes_nxt = block_bytes_r;
    last_seq_nxt    = last_seq_r;
    seq_valid_nxt   = seq_valid_r;
    block_open_nxt  = block_open_r;
    block_count_nxt = block_count_r;
    hdr_seq_nxt     = hdr_seq_r;
    out_nxt         = '0;

    if (take && q_data.cmd) begin
      // Start command clears the run state
      hidx_nxt        = '0;
      slice_bytes_nxt = '0;
      slice_size_nxt  = '0;
      size_bad_nxt    = 1'b1;
      size_hdr_nxt    = 1'b0;
      slices_nxt      = '0;
      block_bytes_nxt = '0;
      last_seq_nxt    = '0;
      seq_valid_nxt   = 1'b0;
      block_open_nxt  = 1'b0;
      block_count_nxt = '0;
      hdr_seq_nxt     = '0;
    end else if (data_take) begin
      // Header capture
      if ((phase_r != msd_pkg::PH_PAYLOAD) && (phase_r != msd_pkg::PH_DISCARD)) begin
        if (hidx_r == 2'd0) begin
          slice_size_nxt = q_data.word;
          size_bad_nxt   = q_data.size_bad;
          size_hdr_nxt   = q_data.size_hdr_only;
        end
        if (hidx_r == 2'd1) begin
          hdr_seq_nxt = q_data.word;
        end
        hidx_nxt = hidx_r + 2'd1;
      end
      if (hdr_last) begin
        last_seq_nxt  = mis ? seq_inc : hdr_seq_r;
        seq_valid_nxt = 1'b1;
      end
      if (close_slice) begin
        hidx_nxt = '0;
      end
      slice_bytes_nxt = close_slice ? '0 : sbs1;
      slices_nxt      = sib1;
      block_bytes_nxt = bbs + 32'(msd_pkg::WORD_BYTES);
      block_open_nxt  = !done;
      block_count_nxt = done ? block_count_r + 32'd1 : block_count_r;

      out_nxt.write_offset = bbs;
      out_nxt.block_done   = done;
      out_nxt.block_bytes  = done ? block_bytes_nxt : '0;
      out_nxt.block_slices = done ? sib1 : '0;
      out_nxt.seq_mismatch = mis;
      out_nxt.got_seq      = hdr_last ? hdr_seq_r : '0;
      out_nxt.expected_seq = hdr_last ? (seq_valid_r ? seq_inc : hdr_seq_r) : '0;
      out_nxt.resync_found = (phase_r == msd_pkg::PH_DISCARD) && q_data.is_safe;
      out_nxt.size_error   = hdr_last && !mis && size_bad_r;
      out_nxt.blocks_total = block_count_nxt;
    end
  end

  // Run state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= msd_pkg::PH_HEADER;
      hidx_r        <= '0;
      slice_bytes_r <= '0;
      slice_size_r  <= '0;
      size_bad_r    <= 1'b1;
      size_hdr_r    <= 1'b0;
      slices_r      <= '0;
      block_bytes_r <= '0;
      last_seq_r    <= '0;
      seq_valid_r   <= 1'b0;
      block_open_r  <= 1'b0;
      block_count_r <= '0;
      hdr_seq_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      hidx_r        <= hidx_nxt;
      slice_bytes_r <= slice_bytes_nxt;
      slice_size_r  <= slice_size_nxt;
      size_bad_r    <= size_bad_nxt;
      size_hdr_r    <= size_hdr_nxt;
      slices_r      <= slices_nxt;
      block_bytes_r <= block_bytes_nxt;
      last_seq_r    <= last_seq_nxt;
      seq_valid_r   <= seq_valid_nxt;
      block_open_r  <= block_open_nxt;
      block_count_r <= block_count_nxt;
      hdr_seq_r     <= hdr_seq_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> rtl/microslice_stream_deframer.sv
// Microslice stream deframer top level: config registers, front, queue, back.
// Throughput: one word per cycle sustained while out_ready is high; every
// word yields one result. Each result passes through the front-to-back
// queue register and then the back end's result register.
// Reset: synchronous active-low rst_n clears run state, empties the queue and
// restores slices_per_block = 1 and safe_word = 0x708b309e.
module microslice_stream_deframer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  msd_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output msd_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [msd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  logic [15:0]        slices_per_block_r;
  logic [31:0]        safe_word_r;
  msd_pkg::cls_item_t cls;
  msd_pkg::cls_item_t q_data;
  logic               q_full, q_valid, q_pop, push;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && !q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slices_per_block_r <= msd_pkg::SLICES_PER_BLOCK_RST;
      safe_word_r        <= msd_pkg::SAFE_WORD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        msd_pkg::CFG_SLICES_PER_BLOCK: slices_per_block_r <= cfg_data[15:0];
        msd_pkg::CFG_SAFE_WORD:        safe_word_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  msd_front u_front (
    .in_data   (in_data),
    .safe_word (safe_word_r),
    .cls       (cls)
  );

  msd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  msd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .slices_per_block (slices_per_block_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

endmodule

>>> tb/sv/deframer_checker.sv
// Deframer checker: predicts each result from accepted requests and compares.
`timescale 1ns / 100ps
module deframer_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  msd_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  msd_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [msd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            error_count,
  output int                            pending_count,
  output int                            results_checked,
  output int                            blocks_seen,
  output int                            slips_seen,
  output int                            size_faults_seen,
  output int                            resyncs_seen
);

  // Register copies
  logic [15:0] spb_cfg;
  logic [31:0] safe_cfg;

  // Run state of the predictor
  msd_pkg::phase_t ph;
  logic [1:0]  hdr_idx;
  logic [31:0] slice_bytes;
  logic [31:0] slice_len;
  logic [15:0] blk_slices;
  logic [31:0] blk_bytes;
  logic [31:0] last_seq;
  logic [31:0] hdr_seq;
  logic        seq_seen;
  logic        blk_open;
  logic [31:0] blocks_done;

  msd_pkg::out_item_t expected_results[$];

  int errors   = 0;
  int checked  = 0;
  int blocks   = 0;
  int slips    = 0;
  int faults   = 0;
  int resyncs  = 0;

  function automatic void clear_run();
    ph          = msd_pkg::PH_HEADER;
    hdr_idx     = '0;
    slice_bytes = '0;
    slice_len   = '0;
    blk_slices  = '0;
    blk_bytes   = '0;
    last_seq    = '0;
    hdr_seq     = '0;
    seq_seen    = 1'b0;
    blk_open    = 1'b0;
    blocks_done = '0;
  endfunction

  function automatic void end_slice();
    blk_slices  = blk_slices + 16'd1;
    slice_bytes = '0;
    hdr_idx     = '0;
    ph          = msd_pkg::PH_HEADER;
  endfunction

  // One word in, one result out; updates the run state
  function automatic msd_pkg::out_item_t deframe_word(msd_pkg::in_item_t req);
    msd_pkg::out_item_t r;
    logic [31:0]        next_seq;
    r = '0;
    if (req.cmd) begin
      clear_run();
      return r;
    end

    if (!blk_open) begin
      blk_open    = 1'b1;
      blk_bytes   = '0;
      blk_slices  = '0;
      slice_bytes = '0;
    end

    r.write_offset = blk_bytes;
    slice_bytes    = slice_bytes + msd_pkg::WORD_BYTES;

    case (ph)
      msd_pkg::PH_PAYLOAD: begin
        if (slice_bytes == slice_len) end_slice();
      end
      msd_pkg::PH_DISCARD: begin
        if (req.data_word == safe_cfg) begin
          r.resync_found = 1'b1;
          end_slice();
        end
      end
      default: begin
        ph = msd_pkg::PH_HEADER;
        if (hdr_idx == 2'd0) slice_len = req.data_word;
        else if (hdr_idx == 2'd1) hdr_seq = req.data_word;
        if (hdr_idx != 2'd3) begin
          hdr_idx = hdr_idx + 2'd1;
        end else begin
          // last header word: sequence check, then size check
          hdr_idx        = '0;
          next_seq       = last_seq + 32'd1;
          r.got_seq      = hdr_seq;
          r.expected_seq = seq_seen ? next_seq : hdr_seq;
          if (seq_seen && hdr_seq != next_seq) begin
            r.seq_mismatch = 1'b1;
            last_seq       = next_seq;
            ph             = msd_pkg::PH_DISCARD;
          end else begin
            last_seq = hdr_seq;
            if (slice_len < msd_pkg::HEADER_BYTES || slice_len[1:0] != 2'b00) begin
              r.size_error = 1'b1;
              ph           = msd_pkg::PH_DISCARD;
            end else if (slice_len == msd_pkg::HEADER_BYTES) begin
              end_slice();
            end else begin
              ph = msd_pkg::PH_PAYLOAD;
            end
          end
          seq_seen = 1'b1;
        end
      end
    endcase

    blk_bytes = blk_bytes + msd_pkg::WORD_BYTES;

    // block closes once the configured slice count is reached
    if (blk_slices == spb_cfg) begin
      r.block_done   = 1'b1;
      r.block_bytes  = blk_bytes;
      r.block_slices = blk_slices;
      blocks_done    = blocks_done + 32'd1;
      blk_open       = 1'b0;
    end
    r.blocks_total = blocks_done;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result %0d field %s expected %h got %h",
                 $time, checked, name, want, seen);
    end
  endfunction

  // Watch all three channels at each edge
  always @(posedge clk) begin : watch
    msd_pkg::out_item_t want;
    if (!rst_n) begin
      spb_cfg  = msd_pkg::SLICES_PER_BLOCK_RST;
      safe_cfg = msd_pkg::SAFE_WORD_RST;
      clear_run();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == msd_pkg::CFG_SLICES_PER_BLOCK) spb_cfg = cfg_data[15:0];
        else if (cfg_index == msd_pkg::CFG_SAFE_WORD) safe_cfg = cfg_data;
      end

      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no request outstanding: %h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          check_field("write_offset", want.write_offset, out_data.write_offset);
          check_field("block_done", 32'(want.block_done), 32'(out_data.block_done));
          check_field("block_bytes", want.block_bytes, out_data.block_bytes);
          check_field("block_slices", 32'(want.block_slices),
                      32'(out_data.block_slices));
          check_field("seq_mismatch", 32'(want.seq_mismatch),
                      32'(out_data.seq_mismatch));
          check_field("got_seq", want.got_seq, out_data.got_seq);
          check_field("expected_seq", want.expected_seq, out_data.expected_seq);
          check_field("resync_found", 32'(want.resync_found),
                      32'(out_data.resync_found));
          check_field("size_error", 32'(want.size_error), 32'(out_data.size_error));
          check_field("blocks_total", want.blocks_total, out_data.blocks_total);
          checked++;
          if (out_data.block_done === 1'b1) blocks++;
          if (out_data.seq_mismatch === 1'b1) slips++;
          if (out_data.size_error === 1'b1) faults++;
          if (out_data.resync_found === 1'b1) resyncs++;
        end
      end

      if (in_valid && in_ready) expected_results.push_back(deframe_word(in_data));
    end

    error_count      <= errors;
    pending_count    <= expected_results.size();
    results_checked  <= checked;
    blocks_seen      <= blocks;
    slips_seen       <= slips;
    size_faults_seen <= faults;
    resyncs_seen     <= resyncs;
  end

endmodule

>>> tb/sv/microslice_stream_deframer_test.sv
// Top of the deframer testbench: clock, reset, word stream, register writes, verdict.
`timescale 1ns / 100ps
module microslice_stream_deframer_test;

  typedef enum {SL_GOOD, SL_BAD_SEQ, SL_BAD_SIZE, SL_CUT} slice_kind_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  msd_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b1;
  msd_pkg::out_item_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [msd_pkg::CFG_IDX_W-1:0] cfg_index = msd_pkg::CFG_SLICES_PER_BLOCK;
  logic [31:0]                   cfg_data  = '0;

  int error_count, pending_count, results_checked;
  int blocks_seen, slips_seen, size_faults_seen, resyncs_seen;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent     = 0;
  int unsigned settings_used  = 0;

  // Sender's view of the sequence, to build well-formed slices
  logic [31:0] next_seq     = '0;
  bit          seq_known    = 1'b0;
  logic [31:0] safe_pattern = msd_pkg::SAFE_WORD_RST;

  microslice_stream_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  deframer_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .error_count      (error_count),
    .pending_count    (pending_count),
    .results_checked  (results_checked),
    .blocks_seen      (blocks_seen),
    .slips_seen       (slips_seen),
    .size_faults_seen (size_faults_seen),
    .resyncs_seen     (resyncs_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Random result backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Overall time limit
  initial begin
    #3_000_000;
    $display("Timed out with %0d results outstanding", pending_count);
    $display("Regression FAIL");
    $finish;
  end

  // One request; valid stays up afterwards unless an idle gap follows
  task automatic send_item(input logic is_start, input logic [31:0] word);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= msd_pkg::in_item_t'{cmd: is_start, data_word: word};
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic start_run();
    send_item(1'b1, $urandom);
    seq_known = 1'b0;
  endtask

  // Drain all outstanding results, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] spb, input logic [31:0] safe);
    logic [31:0] junk;
    junk = $urandom;
    cfg_valid <= 1'b1;
    cfg_index <= msd_pkg::CFG_SLICES_PER_BLOCK;
    cfg_data  <= {junk[15:0], spb};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= msd_pkg::CFG_SAFE_WORD;
    cfg_data  <= safe;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    safe_pattern = safe;
    settings_used++;
  endtask

  // Header plus body; extra = discard words before the safe word, or
  // trailing words of a cut slice
  task automatic send_microslice(input slice_kind_t kind, input logic [31:0] size,
                                 input int unsigned extra);
    logic [31:0] seq;
    logic [31:0] w;
    seq = seq_known ? next_seq : $urandom;
    if (kind == SL_BAD_SEQ) seq = next_seq + $urandom_range(32'hFFFF_FFFF, 1);
    send_item(1'b0, size);
    send_item(1'b0, seq);
    send_item(1'b0, $urandom);
    if (kind == SL_CUT) begin
      repeat (extra) send_item(1'b0, $urandom);
      start_run();
      return;
    end
    send_item(1'b0, $urandom);
    next_seq  = (kind == SL_BAD_SEQ) ? next_seq + 32'd1 : seq + 32'd1;
    seq_known = 1'b1;
    if (kind == SL_GOOD) begin
      repeat ((size - msd_pkg::HEADER_BYTES) / msd_pkg::WORD_BYTES)
        send_item(1'b0, $urandom);
    end else begin
      repeat (extra) begin
        w = $urandom;
        if (w == safe_pattern) w = ~w;
        send_item(1'b0, w);
      end
      send_item(1'b0, safe_pattern);
    end
  endtask

  // Mostly well-formed slices, with slips, bad sizes, cuts and noise
  task automatic send_random_traffic();
    int unsigned pick;
    logic [31:0] size;
    logic [31:0] raw;
    pick = $urandom_range(99, 0);
    raw  = $urandom;
    if (pick < 6) begin
      start_run();
    end else if (pick < 11) begin
      repeat ($urandom_range(4, 1)) send_item(1'b0, $urandom);
      start_run();
    end else if (pick < 19 && seq_known) begin
      send_microslice(SL_BAD_SEQ, raw, $urandom_range(3, 0));
    end else if (pick < 27) begin
      case ($urandom_range(3, 0))
        0: size = 4 * $urandom_range(3, 0);
        1: size = msd_pkg::HEADER_BYTES + 4 * $urandom_range(8, 0) + $urandom_range(3, 1);
        2: size = {raw[31:2], 2'b00} | $urandom_range(3, 1);
        default: size = $urandom_range(15, 0);
      endcase
      send_microslice(SL_BAD_SIZE, size, $urandom_range(3, 0));
    end else if (pick < 31) begin
      send_microslice(SL_CUT, raw, $urandom_range(2, 0));
    end else begin
      if ($urandom_range(99, 0) < 80)
        size = msd_pkg::HEADER_BYTES + 4 * $urandom_range(6, 0);
      else
        size = msd_pkg::HEADER_BYTES + 4 * $urandom_range(24, 0);
      send_microslice(SL_GOOD, size, 0);
    end
  endtask

  initial begin
    int unsigned target;
    logic [15:0] spb;
    logic [31:0] safe;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: word extremes, header-only slice, sequence wrap, slip, bad sizes
    send_item(1'b1, 32'hFFFF_FFFF);
    send_item(1'b0, msd_pkg::HEADER_BYTES);
    send_item(1'b0, 32'hFFFF_FFFF);
    send_item(1'b0, 32'h0000_0000);
    send_item(1'b0, 32'hFFFF_FFFF);
    seq_known = 1'b1;
    next_seq  = '0;
    send_microslice(SL_GOOD, 32'd20, 0);
    send_microslice(SL_BAD_SEQ, 32'd24, 1);
    send_microslice(SL_BAD_SIZE, 32'd18, 0);
    send_microslice(SL_BAD_SIZE, 32'd12, 0);

    // Random phases, each with its own register setting and idle pattern
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      case (p)
        0: begin spb = 16'd1;     safe = 32'h0000_0000; end
        1: begin spb = 16'd0;     safe = 32'hFFFF_FFFF; end
        2: begin spb = 16'hFFFF;  safe = $urandom;      end
        3: begin spb = 16'd2;     safe = msd_pkg::SAFE_WORD_RST; end
        default: begin spb = 16'($urandom_range(4, 1)); safe = $urandom; end
      endcase
      program_regs(spb, safe);
      start_run();
      target = words_sent + 220;
      while (words_sent < target) send_random_traffic();
    end

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d words under %0d register settings; %0d results checked",
             words_sent, settings_used + 1, results_checked);
    $display("Blocks closed %0d, sequence slips %0d, size faults %0d, resyncs %0d",
             blocks_seen, slips_seen, size_faults_seen, resyncs_seen);
    if (error_count == 0 && pending_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
